FILE: hdl/image_to_column_2d_defines.svh
// Assertion macros shared by the im2col RTL modules.
// Needs clk and rst_n in the module that uses them; no other dependencies.
`ifndef IMAGE_TO_COLUMN_2D_DEFINES_SVH
`define IMAGE_TO_COLUMN_2D_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define IM2COL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define IM2COL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/im2col_pkg.sv
// Shared types and constants for the im2col block.
// No dependencies; imported by every module of the block.
package im2col_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_DIMS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_DIMS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIMS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DILATION_DIMS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_VALUE     = 3'd7;

  // Width of the unreduced linear source address: (6*127+126)*127+126 < 2**17
  localparam int SRC_AW = 17;

  // Output-size divider: numerator up to 156, divisor is a 4-bit stride
  localparam int DIV_NUM_W = 8;
  localparam int DIV_DEN_W = 4;

  localparam logic [6:0] OUT_DIM_MAX = 7'd127;

  typedef struct packed {
    logic        kind;
    logic [13:0] pixel_addr;
    logic [15:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] col_value;
    logic        is_pad;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  channel_count;
    logic [6:0]  image_height;
    logic [6:0]  image_width;
    logic [7:0]  kernel_dims;
    logic [7:0]  pad_dims;
    logic [7:0]  stride_dims;
    logic [7:0]  dilation_dims;
    logic [15:0] pad_value;
  } cfg_t;

  typedef struct packed {
    logic snap;
    logic div_start;
    logic dims_latch;
    logic clr_walk;
    logic mem_write;
    logic read_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic dims_zero;
    logic last;
  } dp_sts_t;

endpackage

FILE: hdl/im2col_div.sv
// Two-lane restoring divider, one quotient bit per cycle, for the output sizes.
// Depends on im2col_pkg and the assertion macros header.
`include "image_to_column_2d_defines.svh"

module im2col_div
  import im2col_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [1:0][DIV_NUM_W-1:0]           num,
  input  logic [1:0][DIV_DEN_W-1:0]           den,
  output logic [1:0][DIV_NUM_W-1:0]           quo,
  output logic                                done
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [1:0][DIV_NUM_W-1:0] num_r, num_nxt;
  logic [1:0][DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [1:0][DIV_DEN_W-1:0] den_r;
  logic [1:0][DIV_DEN_W:0]   rem_sh;
  logic [1:0]                ge;
  logic [CNT_W-1:0]          cnt_r;
  logic                      run_r;
  logic                      done_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l]  = {rem_r[l], num_r[l][DIV_NUM_W-1]};
      ge[l]      = rem_sh[l] >= {1'b0, den_r[l]};
      rem_nxt[l] = ge[l] ? DIV_DEN_W'(rem_sh[l] - {1'b0, den_r[l]})
                         : rem_sh[l][DIV_DEN_W-1:0];
      num_nxt[l] = {num_r[l][DIV_NUM_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= '0;
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quo  = num_r;
  assign done = done_r;

  `IM2COL_ASSERT_NXT(a_start_clears_done, start, !done_r, "divider done flag survived a start")

endmodule

FILE: hdl/im2col_dp.sv
// Datapath: geometry snapshot, walk counters, address arithmetic, image store.
// Depends on im2col_pkg, im2col_div and the assertion macros header.
`include "image_to_column_2d_defines.svh"

module im2col_dp
  import im2col_pkg::*;
#(
  parameter int IMAGE_DEPTH = 16384,
  parameter int DATA_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  output out_item_t out_item
);

  localparam int MEM_W   = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int MAW     = $clog2(IMAGE_DEPTH);
  localparam int RECIP   = (1 << SRC_AW) / IMAGE_DEPTH;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam logic [SRC_AW-1:0]  DEPTH_C = SRC_AW'(IMAGE_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  function automatic logic [3:0] at_least_one(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

  // Geometry snapshot
  logic [2:0]  g_chans_r;
  logic [6:0]  g_h_r, g_w_r;
  logic [3:0]  g_kh_r, g_kw_r, g_ph_r, g_pw_r, g_sh_r, g_sw_r, g_dh_r, g_dw_r;
  logic [15:0] g_padv_r;

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      g_chans_r <= (cfg.channel_count == 3'd0) ? 3'd1 : cfg.channel_count;
      g_h_r     <= cfg.image_height;
      g_w_r     <= cfg.image_width;
      g_kh_r    <= at_least_one(cfg.kernel_dims[7:4]);
      g_kw_r    <= at_least_one(cfg.kernel_dims[3:0]);
      g_ph_r    <= cfg.pad_dims[7:4];
      g_pw_r    <= cfg.pad_dims[3:0];
      g_sh_r    <= at_least_one(cfg.stride_dims[7:4]);
      g_sw_r    <= at_least_one(cfg.stride_dims[3:0]);
      g_dh_r    <= at_least_one(cfg.dilation_dims[7:4]);
      g_dw_r    <= at_least_one(cfg.dilation_dims[3:0]);
      g_padv_r  <= cfg.pad_value;
    end
  end

  // Output size numerators: size + 2*pad - (dil*(k-1)+1), two's complement
  logic [7:0] span_h, span_w;
  logic [9:0] num_h, num_w;
  logic       neg_h_r, neg_w_r;
  logic [1:0][DIV_NUM_W-1:0] div_num, div_quo;
  logic [1:0][DIV_DEN_W-1:0] div_den;
  logic       div_done;

  always_comb begin
    span_h = {4'd0, g_dh_r} * {4'd0, 4'(g_kh_r - 4'd1)};
    span_w = {4'd0, g_dw_r} * {4'd0, 4'(g_kw_r - 4'd1)};
    num_h  = {3'd0, g_h_r} + {5'd0, g_ph_r, 1'b0} - {2'd0, span_h} - 10'd1;
    num_w  = {3'd0, g_w_r} + {5'd0, g_pw_r, 1'b0} - {2'd0, span_w} - 10'd1;
    div_num[0] = num_h[DIV_NUM_W-1:0];
    div_num[1] = num_w[DIV_NUM_W-1:0];
    div_den[0] = g_sh_r;
    div_den[1] = g_sw_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_h_r <= num_h[9];
      neg_w_r <= num_w[9];
    end
  end

  im2col_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  logic [8:0] q1_h, q1_w;
  logic [6:0] out_h_r, out_w_r;

  assign q1_h = {1'b0, div_quo[0]} + 9'd1;
  assign q1_w = {1'b0, div_quo[1]} + 9'd1;

  // Saturate the output sizes, zero when the kernel overhangs the padded image
  always_ff @(posedge clk) begin
    if (cmd.dims_latch) begin
      out_h_r <= neg_h_r ? 7'd0 : ((q1_h > {2'd0, OUT_DIM_MAX}) ? OUT_DIM_MAX : q1_h[6:0]);
      out_w_r <= neg_w_r ? 7'd0 : ((q1_w > {2'd0, OUT_DIM_MAX}) ? OUT_DIM_MAX : q1_w[6:0]);
    end
  end

  // Walk counters: channel, kernel row, kernel column, output row, output column
  logic [2:0] chan_idx_r;
  logic [3:0] krow_idx_r, kcol_idx_r;
  logic [6:0] orow_idx_r, ocol_idx_r;
  logic       oc_wrap, or_wrap, kc_wrap, kr_wrap, ch_wrap, walk_last;

  always_comb begin
    oc_wrap   = ({1'b0, ocol_idx_r} + 8'd1) >= {1'b0, out_w_r};
    or_wrap   = ({1'b0, orow_idx_r} + 8'd1) >= {1'b0, out_h_r};
    kc_wrap   = ({1'b0, kcol_idx_r} + 5'd1) >= {1'b0, g_kw_r};
    kr_wrap   = ({1'b0, krow_idx_r} + 5'd1) >= {1'b0, g_kh_r};
    ch_wrap   = ({1'b0, chan_idx_r} + 4'd1) >= {1'b0, g_chans_r};
    walk_last = oc_wrap && or_wrap && kc_wrap && kr_wrap && ch_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_walk) begin
      chan_idx_r <= '0;
      krow_idx_r <= '0;
      kcol_idx_r <= '0;
      orow_idx_r <= '0;
      ocol_idx_r <= '0;
    end else if (cmd.read_adv) begin
      if (!oc_wrap) begin
        ocol_idx_r <= ocol_idx_r + 7'd1;
      end else begin
        ocol_idx_r <= '0;
        if (!or_wrap) begin
          orow_idx_r <= orow_idx_r + 7'd1;
        end else begin
          orow_idx_r <= '0;
          if (!kc_wrap) begin
            kcol_idx_r <= kcol_idx_r + 4'd1;
          end else begin
            kcol_idx_r <= '0;
            if (!kr_wrap) begin
              krow_idx_r <= krow_idx_r + 4'd1;
            end else begin
              krow_idx_r <= '0;
              chan_idx_r <= ch_wrap ? 3'd0 : chan_idx_r + 3'd1;
            end
          end
        end
      end
    end
  end

  // Address pipeline; operands hold steady from the first stage to the read
  logic [10:0]              prod_rs_r, prod_cs_r;
  logic [7:0]               prod_rd_r, prod_cd_r;
  logic [9:0]               chan_h_r;
  logic [12:0]              src_row, src_col;
  logic                     pad_row, pad_col, pad_r;
  logic [9:0]               row_base_r;
  logic [6:0]               src_col_lo_r;
  logic [SRC_AW-1:0]        addr_r, addr2_r, rest_r, rd_addr;
  logic [SRC_AW+RECIP_W-1:0] qprod;
  logic [RECIP_W-1:0]       q_est_r;
  logic [MAW-1:0]           rd_idx;

  always_comb begin
    src_row = {2'd0, prod_rs_r} + {5'd0, prod_rd_r} - {9'd0, g_ph_r};
    src_col = {2'd0, prod_cs_r} + {5'd0, prod_cd_r} - {9'd0, g_pw_r};
    pad_row = src_row[12] || (src_row[11:0] >= {5'd0, g_h_r});
    pad_col = src_col[12] || (src_col[11:0] >= {5'd0, g_w_r});
    qprod   = addr_r * RECIP_C;
    // Reciprocal estimate is at most one short: one compare and subtract
    rd_addr = (rest_r >= DEPTH_C) ? SRC_AW'(rest_r - DEPTH_C) : rest_r;
    rd_idx  = rd_addr[MAW-1:0];
  end

  always_ff @(posedge clk) begin
    prod_rs_r    <= {4'd0, orow_idx_r} * {7'd0, g_sh_r};
    prod_rd_r    <= {4'd0, krow_idx_r} * {4'd0, g_dh_r};
    prod_cs_r    <= {4'd0, ocol_idx_r} * {7'd0, g_sw_r};
    prod_cd_r    <= {4'd0, kcol_idx_r} * {4'd0, g_dw_r};
    chan_h_r     <= {7'd0, chan_idx_r} * {3'd0, g_h_r};
    pad_r        <= pad_row || pad_col;
    row_base_r   <= chan_h_r + {3'd0, src_row[6:0]};
    src_col_lo_r <= src_col[6:0];
    addr_r       <= SRC_AW'({7'd0, row_base_r} * {10'd0, g_w_r}) + {10'd0, src_col_lo_r};
    q_est_r      <= qprod[SRC_AW +: RECIP_W];
    addr2_r      <= addr_r;
    rest_r       <= addr2_r - SRC_AW'(q_est_r * DEPTH_C);
  end

  // Image store
  logic [MEM_W-1:0] mem [IMAGE_DEPTH];
  logic [MEM_W-1:0] rd_data_r;
  logic             pad_out_r, last_out_r;
  logic             wr_ok;
  logic [MAW-1:0]   wr_idx;

  assign wr_ok  = {3'd0, in_item.pixel_addr} < DEPTH_C;
  assign wr_idx = MAW'(in_item.pixel_addr);

  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_ok) begin
      mem[wr_idx] <= MEM_W'(in_item.pixel_value);
    end
    if (cmd.read_adv) begin
      rd_data_r  <= mem[rd_idx];
      pad_out_r  <= pad_r;
      last_out_r <= walk_last;
    end
  end

  assign out_item.col_value = pad_out_r ? g_padv_r : 16'(rd_data_r);
  assign out_item.is_pad    = pad_out_r;
  assign out_item.last      = last_out_r;

  assign sts.div_done  = div_done;
  assign sts.dims_zero = neg_h_r || neg_w_r;
  assign sts.last      = walk_last;

  `IM2COL_ASSERT_NXT(a_dims_nonzero, cmd.dims_latch && !sts.dims_zero, out_h_r != 7'd0 && out_w_r != 7'd0, "output size latched as zero on a live walk")
  `IM2COL_ASSERT_NXT(a_idx_in_range, cmd.read_adv && !walk_last, ocol_idx_r < out_w_r && orow_idx_r < out_h_r && kcol_idx_r < g_kw_r, "walk counter left its range")

endmodule

FILE: hdl/im2col_ctrl.sv
// Controller: command decode, walk run state and per-element sequencing.
// Depends on im2col_pkg and the assertion macros header.
`include "image_to_column_2d_defines.svh"

module im2col_ctrl
  import im2col_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      kind,
  input  dp_sts_t   sts,
  output logic      busy,
  output ctrl_cmd_t cmd,
  output logic      out_valid
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_NUM  = 11'b000_0000_0010,
    S_DIV  = 11'b000_0000_0100,
    S_DIMS = 11'b000_0000_1000,
    S_P1   = 11'b000_0001_0000,
    S_P2   = 11'b000_0010_0000,
    S_P3   = 11'b000_0100_0000,
    S_P4   = 11'b000_1000_0000,
    S_P5   = 11'b001_0000_0000,
    S_P6   = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    RUN_IDLE = 3'b001,
    RUN_BUSY = 3'b010,
    RUN_DONE = 3'b100
  } run_t;

  state_t state_r, state_nxt;
  run_t   run_r, run_nxt;
  logic   accept;

  assign busy      = !(state_r == S_IDLE || state_r == S_OUT);
  assign accept    = start && !busy;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    run_nxt   = run_r;
    unique case (state_r)
      S_IDLE: state_nxt = S_IDLE;
      S_NUM: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_DIMS;
        end
      end
      S_DIMS: begin
        cmd.dims_latch = 1'b1;
        if (sts.dims_zero) begin
          run_nxt   = RUN_DONE;
          state_nxt = S_IDLE;
        end else begin
          run_nxt   = RUN_BUSY;
          state_nxt = S_P1;
        end
      end
      S_P1: state_nxt = S_P2;
      S_P2: state_nxt = S_P3;
      S_P3: state_nxt = S_P4;
      S_P4: state_nxt = S_P5;
      S_P5: state_nxt = S_P6;
      S_P6: begin
        cmd.read_adv = 1'b1;
        if (sts.last) begin
          run_nxt = RUN_DONE;
        end
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    // Load resets the walk; emit starts, continues or skips a done walk
    if (accept) begin
      priority if (kind == KIND_LOAD) begin
        cmd.mem_write = 1'b1;
        cmd.clr_walk  = 1'b1;
        run_nxt       = RUN_IDLE;
        state_nxt     = S_IDLE;
      end else begin
        unique case (run_r)
          RUN_IDLE: begin
            cmd.snap  = 1'b1;
            state_nxt = S_NUM;
          end
          RUN_BUSY: state_nxt = S_P1;
          RUN_DONE: state_nxt = S_IDLE;
          default:  state_nxt = S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r   <= RUN_IDLE;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
    end
  end

  `IM2COL_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe held for two cycles")
  `IM2COL_ASSERT_NXT(a_last_ends_walk, cmd.read_adv && sts.last, run_r == RUN_DONE, "walk not closed after its final element")
  `IM2COL_ASSERT_IMP(a_div_while_idle, state_r == S_DIV || state_r == S_NUM, run_r == RUN_IDLE, "size computation outside walk start")

endmodule

FILE: hdl/image_to_column_2d.sv
// im2col top level: configuration registers, controller and datapath with image store.
// Emit beat: result strobed once the address multiply/reduce chain and the store read
// are through; the next beat is taken in the strobe cycle, and not before it.
// First emit of a walk adds the snapshot and 8-step size divider; loads stay idle.
// Sync active-low reset clears control, presets the config; the store is not cleared.
module image_to_column_2d
  import im2col_pkg::*;
#(
  parameter int IMAGE_DEPTH = 16384,
  parameter int DATA_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count <= 3'd1;
      cfg_r.image_height  <= 7'd8;
      cfg_r.image_width   <= 7'd8;
      cfg_r.kernel_dims   <= 8'h33;
      cfg_r.pad_dims      <= 8'h11;
      cfg_r.stride_dims   <= 8'h11;
      cfg_r.dilation_dims <= 8'h11;
      cfg_r.pad_value     <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_data[2:0];
        CFG_IMAGE_HEIGHT:  cfg_r.image_height  <= cfg_data[6:0];
        CFG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_data[6:0];
        CFG_KERNEL_DIMS:   cfg_r.kernel_dims   <= cfg_data[7:0];
        CFG_PAD_DIMS:      cfg_r.pad_dims      <= cfg_data[7:0];
        CFG_STRIDE_DIMS:   cfg_r.stride_dims   <= cfg_data[7:0];
        CFG_DILATION_DIMS: cfg_r.dilation_dims <= cfg_data[7:0];
        CFG_PAD_VALUE:     cfg_r.pad_value     <= cfg_data;
      endcase
    end
  end

  im2col_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_item.kind),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  im2col_dp #(
    .IMAGE_DEPTH (IMAGE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
